// ===== sv/page_framebuffer_draw_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Page framebuffer draw engine: assertion macros
// Shared concurrent check forms, clocked on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// same-cycle implication
`define PFDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg
// Command codes, default panel size and the pixel unit status struct.
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 32;

  // byte index width covering the largest panel (256 x 64 / 8 bytes)
  localparam int IDX_W = 11;

  localparam logic [2:0] FN_PIXEL  = 3'd0;
  localparam logic [2:0] FN_HLINE  = 3'd1;
  localparam logic [2:0] FN_VLINE  = 3'd2;
  localparam logic [2:0] FN_RECT   = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;
  localparam logic [2:0] FN_BITMAP = 3'd5;
  localparam logic [2:0] FN_READ   = 3'd6;

  typedef struct packed {
    logic             in_panel;
    logic [IDX_W-1:0] idx;
    logic [2:0]       bit_sel;
  } pfde_pix_t;

endpackage

// ===== sv/pfde_ram.sv =====
// ----------------------------------------------------------------------------
// pfde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pfde_pix_unit.sv =====
// ----------------------------------------------------------------------------
// pfde_pix_unit
// Shared pixel unit: panel bounds check, page byte index, bit merge.
// ----------------------------------------------------------------------------
module pfde_pix_unit
  import pfde_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic [7:0] px,
  input  logic [7:0] py,
  input  logic       value,
  input  logic [7:0] old_byte,
  output pfde_pix_t  pix,
  output logic [7:0] new_byte
);

  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;

  logic [IDX_W-1:0] idx;
  logic [7:0]       mask;

  always_comb begin
    idx = IDX_W'(px) + IDX_W'(py[5:3]) * IDX_W'(PANEL_WIDTH);
    pix.idx      = idx;
    pix.bit_sel  = py[2:0];
    pix.in_panel = ({1'b0, px} < 9'(PANEL_WIDTH)) &&
                   ({1'b0, py} < 9'(PANEL_HEIGHT)) &&
                   ({1'b0, idx} < (IDX_W + 1)'(STORE_BYTES));
    mask     = 8'(1) << py[2:0];
    new_byte = value ? (old_byte | mask) : (old_byte & ~mask);
  end

endmodule

// ===== sv/page_framebuffer_draw_engine.sv =====
// Sequence: pixel goes S_PIX, S_WR, S_DONE (S_PIX, S_DONE off the panel); line,
// rect and bitmap pass S_PIX and S_WR per on-panel pixel, S_PIX per off-panel
// pixel. Read goes S_RDA, S_RDW (neither out of range); clear sweeps S_CLR over
// all STORE_BYTES; empty or unused go to S_DONE. One request at a time; busy
// stays high through done and the next request is accepted from the cycle after
// done. The receiver cannot stall. Reset: clears all STORE_BYTES with busy high.
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Page-organized monochrome frame store with pixel, line, rectangle,
// bitmap, clear and read-back requests under a small sequencer.
// ----------------------------------------------------------------------------
`include "page_framebuffer_draw_engine_defines.svh"

module page_framebuffer_draw_engine
  import pfde_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] func,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] length,
  input  logic [7:0] height,
  input  logic       color,
  input  logic [7:0] pattern,
  input  logic [8:0] read_index,
  output logic       done,
  output logic [7:0] read_data,
  output logic       clipped
);

  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
  localparam int AW          = $clog2(STORE_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_PIX  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_RDA  = 3'd4;
  localparam logic [2:0] S_RDW  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          clr_report, clr_report_next;
  logic [2:0]    fn;
  logic [7:0]    x0, y0, pat, cols, rows, i, j;
  logic          col_r;
  logic [8:0]    ridx;
  logic [7:0]    res_data;
  logic          res_clip;

  pfde_pix_t     pix;
  logic [7:0]    px, py, new_byte, ram_q;
  logic          value;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata;
  logic          accept, last_col, last_row;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign done     = (state == S_DONE);
  assign read_data = res_data;
  assign clipped   = res_clip;

  assign px       = x0 + i;
  assign py       = y0 + j;
  assign value    = (fn == FN_BITMAP) ? pat[~i[2:0]] : col_r;
  assign last_col = (i == cols - 8'd1);
  assign last_row = (j == rows - 8'd1);

  pfde_pix_unit #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_pix (
    .px      (px),
    .py      (py),
    .value   (value),
    .old_byte(ram_q),
    .pix     (pix),
    .new_byte(new_byte)
  );

  pfde_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  always_comb begin
    ram_we    = (state == S_CLR) || (state == S_WR);
    ram_waddr = (state == S_CLR) ? clr_addr : AW'(pix.idx);
    ram_wdata = (state == S_CLR) ? 8'd0 : new_byte;
    ram_raddr = (state == S_RDA) ? AW'(ridx) : AW'(pix.idx);
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    clr_report_next = clr_report;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          clr_addr_next   = '0;
          clr_report_next = 1'b1;
          unique case (func)
            FN_PIXEL: state_next = S_PIX;
            FN_HLINE, FN_BITMAP: state_next = (length == 8'd0) ? S_DONE : S_PIX;
            FN_VLINE: state_next = (length == 8'd0) ? S_DONE : S_PIX;
            FN_RECT: begin
              state_next = (length == 8'd0 || height == 8'd0) ? S_DONE : S_PIX;
            end
            FN_CLEAR: state_next = S_CLR;
            FN_READ: begin
              state_next = (12'(read_index) < 12'(STORE_BYTES)) ? S_RDA : S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(STORE_BYTES - 1)) begin
          state_next = clr_report ? S_DONE : S_IDLE;
        end
      end
      S_PIX: begin
        if (pix.in_panel) begin
          state_next = S_WR;
        end else if (last_col && last_row) begin
          state_next = S_DONE;
        end
      end
      S_WR: begin
        state_next = (last_col && last_row) ? S_DONE : S_PIX;
      end
      S_RDA:   state_next = S_RDW;
      S_RDW:   state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      clr_report <= clr_report_next;
    end
  end

  // request fields, loop counters and result
  always_ff @(posedge clk) begin
    if (accept) begin
      fn       <= func;
      x0       <= x;
      y0       <= y;
      pat      <= pattern;
      ridx     <= read_index;
      col_r    <= (func == FN_RECT) ? 1'b0 : color;
      i        <= '0;
      j        <= '0;
      res_data <= '0;
      res_clip <= 1'b0;
      unique case (func)
        FN_HLINE: begin
          cols <= length;
          rows <= 8'd1;
        end
        FN_VLINE: begin
          cols <= 8'd1;
          rows <= length;
        end
        FN_RECT: begin
          cols <= length;
          rows <= height;
        end
        FN_BITMAP: begin
          cols <= (length > 8'd8) ? 8'd8 : length;
          rows <= 8'd1;
        end
        default: begin
          cols <= 8'd1;
          rows <= 8'd1;
        end
      endcase
    end else begin
      if ((state == S_PIX && !pix.in_panel) || state == S_WR) begin
        if (state == S_PIX) begin
          res_clip <= 1'b1;
        end
        if (last_col) begin
          i <= '0;
          j <= j + 8'd1;
        end else begin
          i <= i + 8'd1;
        end
      end
      if (state == S_RDW) begin
        res_data <= ram_q;
      end
    end
  end

  `PFDE_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
  `PFDE_ASSERT_NEXT(a_done_idle, done, !busy, "engine not idle after result")
  `PFDE_ASSERT_NOW(a_write_busy, ram_we, busy, "frame store written while idle")
  `PFDE_ASSERT_NOW(a_read_noclip, done && fn == FN_READ, !clipped, "read flagged clipped")

endmodule

// ===== tb/page_framebuffer_draw_engine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_checker
// Watches the request and done channels of the draw engine, keeps a shadow
// of the page-organized frame store, predicts read_data and clipped for
// every accepted request and compares them in order with each done strobe.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_checker
  import pfde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] func,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] length,
  input  logic [7:0] height,
  input  logic       color,
  input  logic [7:0] pattern,
  input  logic [8:0] read_index,
  input  logic       done,
  input  logic [7:0] read_data,
  input  logic       clipped,
  output int         fail_count,
  output int         pending
);

  localparam int PANEL_W     = DEF_PANEL_WIDTH;
  localparam int PANEL_H     = DEF_PANEL_HEIGHT;
  localparam int STORE_BYTES = PANEL_W * PANEL_H / 8;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clipped;
  } draw_result_t;

  logic [7:0]   shadow_store [STORE_BYTES];
  draw_result_t expected_results [$];

  assign pending = expected_results.size();

  // returns 1 when the pixel is off the panel and skipped
  function automatic logic plot_pixel(input int px, input int py, input logic val);
    int idx;
    if (px >= PANEL_W || py >= PANEL_H) return 1'b1;
    idx = px + (py / 8) * PANEL_W;
    shadow_store[idx][py % 8] = val;
    return 1'b0;
  endfunction

  function automatic draw_result_t apply_request(
    input logic [2:0] f, input logic [7:0] px, input logic [7:0] py,
    input logic [7:0] len, input logic [7:0] hgt, input logic col,
    input logic [7:0] pat, input logic [8:0] ridx);
    draw_result_t res;
    int           run;
    res = '0;
    case (f)
      FN_PIXEL:
        res.clipped = plot_pixel(px, py, col);
      FN_HLINE:
        for (int i = 0; i < len; i++)
          res.clipped |= plot_pixel((px + i) % 256, py, col);
      FN_VLINE:
        for (int i = 0; i < len; i++)
          res.clipped |= plot_pixel(px, (py + i) % 256, col);
      FN_RECT:
        for (int j = 0; j < hgt; j++)
          for (int i = 0; i < len; i++)
            res.clipped |= plot_pixel((px + i) % 256, (py + j) % 256, 1'b0);
      FN_CLEAR:
        foreach (shadow_store[k]) shadow_store[k] = '0;
      FN_BITMAP: begin
        run = (len > 8) ? 8 : int'(len);
        for (int i = 0; i < run; i++)
          res.clipped |= plot_pixel((px + i) % 256, py, pat[7 - i]);
      end
      FN_READ:
        if (ridx < STORE_BYTES) res.read_data = shadow_store[ridx];
      default: ;
    endcase
    return res;
  endfunction

  initial begin
    fail_count = 0;
    foreach (shadow_store[k]) shadow_store[k] = '0;
  end

  always @(posedge clk) begin
    draw_result_t exp_res;
    if (rst) begin
      foreach (shadow_store[k]) shadow_store[k] = '0;
      expected_results.delete();
    end else begin
      // compare before predicting; busy is high with done, so a done and an accept never share an edge
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected done, read_data %0h clipped %0b",
                   $time, read_data, clipped);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (read_data !== exp_res.read_data) begin
            $display("%0t: read_data expected %0h actual %0h",
                     $time, exp_res.read_data, read_data);
            fail_count++;
          end
          if (clipped !== exp_res.clipped) begin
            $display("%0t: clipped expected %0b actual %0b",
                     $time, exp_res.clipped, clipped);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_request(func, x, y, length, height,
                                                 color, pattern, read_index));
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the draw engine with a directed set of edge-case requests and then
// 1250 random requests with random gaps; the checker beside the block
// predicts and compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import pfde_pkg::*;

  localparam logic [2:0] FN_NONE = 3'd7;
  localparam int RANDOM_REQUESTS = 1250;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] func = '0;
  logic [7:0] x = '0;
  logic [7:0] y = '0;
  logic [7:0] length = '0;
  logic [7:0] height = '0;
  logic       color = 1'b0;
  logic [7:0] pattern = '0;
  logic [8:0] read_index = '0;
  logic       done;
  logic [7:0] read_data;
  logic       clipped;

  int fail_count;
  int pending;
  bit no_gap = 1'b0;

  always #2 clk = ~clk;

  page_framebuffer_draw_engine u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .x(x), .y(y), .length(length), .height(height), .color(color),
    .pattern(pattern), .read_index(read_index), .done(done),
    .read_data(read_data), .clipped(clipped)
  );

  page_framebuffer_draw_engine_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .x(x), .y(y), .length(length), .height(height), .color(color),
    .pattern(pattern), .read_index(read_index), .done(done),
    .read_data(read_data), .clipped(clipped),
    .fail_count(fail_count), .pending(pending)
  );

  // returns at the edge where the request is accepted
  task automatic send_request(
    input logic [2:0] f, input logic [7:0] px, input logic [7:0] py,
    input logic [7:0] len, input logic [7:0] hgt, input logic col,
    input logic [7:0] pat, input logic [8:0] ridx);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    func       <= f;
    x          <= px;
    y          <= py;
    length     <= len;
    height     <= hgt;
    color      <= col;
    pattern    <= pat;
    read_index <= ridx;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    #40_000_000;
    $display("[page_framebuffer_draw_engine] ERROR");
    $finish;
  end

  initial begin
    int         sel;
    int         shape;
    logic [2:0] f;
    logic [7:0] px, py, len, hgt;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every request type, clipping, wrap, saturation
    send_request(FN_READ,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 9'd0);
    send_request(FN_PIXEL,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_PIXEL,  8'd127, 8'd31,  8'd255, 8'd255, 1'b1, 8'hFF, 9'h1FF);
    send_request(FN_PIXEL,  8'd128, 8'd0,   8'd0,   8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_PIXEL,  8'd0,   8'd32,  8'd0,   8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_PIXEL,  8'd255, 8'd255, 8'd0,   8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_READ,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 9'd0);
    send_request(FN_READ,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 9'h1FF);
    send_request(FN_HLINE,  8'd0,   8'd5,   8'd255, 8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_HLINE,  8'd120, 8'd9,   8'd20,  8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_HLINE,  8'd250, 8'd10,  8'd10,  8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_VLINE,  8'd3,   8'd0,   8'd255, 8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_VLINE,  8'd7,   8'd28,  8'd8,   8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_VLINE,  8'd9,   8'd250, 8'd0,   8'd0,   1'b1, 8'h00, 9'd0);
    send_request(FN_PIXEL,  8'd3,   8'd4,   8'd0,   8'd0,   1'b0, 8'h00, 9'd0);
    send_request(FN_RECT,   8'd0,   8'd0,   8'd0,   8'd20,  1'b0, 8'h00, 9'd0);
    send_request(FN_RECT,   8'd0,   8'd0,   8'd20,  8'd0,   1'b0, 8'h00, 9'd0);
    send_request(FN_RECT,   8'd2,   8'd2,   8'd4,   8'd6,   1'b1, 8'h00, 9'd0);
    send_request(FN_BITMAP, 8'd40,  8'd12,  8'd8,   8'd0,   1'b0, 8'hA5, 9'd0);
    send_request(FN_BITMAP, 8'd60,  8'd13,  8'd12,  8'd0,   1'b1, 8'h5A, 9'd0);
    send_request(FN_BITMAP, 8'd80,  8'd14,  8'd0,   8'd0,   1'b1, 8'hFF, 9'd0);
    send_request(FN_BITMAP, 8'd124, 8'd15,  8'd8,   8'd0,   1'b0, 8'hFF, 9'd0);
    send_request(FN_NONE,   8'd1,   8'd1,   8'd1,   8'd1,   1'b1, 8'hFF, 9'd1);
    send_request(FN_RECT,   8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 8'h00, 9'd0);
    send_request(FN_CLEAR,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'h00, 9'd0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) no_gap = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if      (sel < 25) f = FN_PIXEL;
      else if (sel < 40) f = FN_HLINE;
      else if (sel < 55) f = FN_VLINE;
      else if (sel < 65) f = FN_RECT;
      else if (sel < 67) f = FN_CLEAR;
      else if (sel < 82) f = FN_BITMAP;
      else if (sel < 97) f = FN_READ;
      else               f = FN_NONE;
      px  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 127));
      py  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 31));
      len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 16));
      hgt = 8'($urandom_range(0, 255));
      if (f == FN_BITMAP) len = 8'($urandom_range(0, 12));
      if (f == FN_RECT) begin
        // keep most rectangles small; a few long thin ones
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
          len = 8'($urandom_range(0, 255));
          hgt = 8'($urandom_range(0, 4));
        end else if (shape == 1) begin
          len = 8'($urandom_range(0, 4));
          hgt = 8'($urandom_range(0, 255));
        end else begin
          len = 8'($urandom_range(0, 16));
          hgt = 8'($urandom_range(0, 16));
        end
      end
      send_request(f, px, py, len, hgt, 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[page_framebuffer_draw_engine] OK");
    end else begin
      $display("[page_framebuffer_draw_engine] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/pfde_pkg.sv
sv/pfde_ram.sv
sv/pfde_pix_unit.sv
sv/page_framebuffer_draw_engine.sv
tb/page_framebuffer_draw_engine_checker.sv
tb/testbench.sv
